// File: rtl/core/e2q_pkg.sv
// Shared constants and types for the Euler-angle to quaternion converter.
// No dependencies; used by euler_to_quaternion and its port checker.
package e2q_pkg;

   localparam int CORDIC_STAGES = 16;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NUM_ORDERS    = 12;

   // Stage map: input, quadrant reduction, CORDIC iterations, quadrant fix,
   // pair products, triple products, signed sums, rounded output.
   localparam int NUM_STAGES = CORDIC_STAGES + 7;

   localparam logic [3:0] AXIS_ORDER_XYZ = 4'd1;
   localparam logic [3:0] AXIS_ORDER_MAX = 4'd11;

   // Half-angle constants, Q.30 radians
   localparam logic signed [33:0] PI_QUARTER   = 34'sd843314857;
   localparam logic signed [33:0] PI_HALF      = 34'sd1686629713;
   localparam logic signed [33:0] PI_HALF_X2   = 34'sd3373259426;
   localparam logic signed [33:0] PI_HALF_X3   = 34'sd5059889139;
   localparam logic signed [33:0] QUAD_LIMIT_1 = 34'sd843314857;
   localparam logic signed [33:0] QUAD_LIMIT_2 = 34'sd2529944570;
   localparam logic signed [33:0] QUAD_LIMIT_3 = 34'sd4216574283;
   localparam logic signed [32:0] CORDIC_GAIN  = 33'sd652032874;

   localparam logic [30:0] ATAN_Q30 [ATAN_ENTRIES] = '{
      31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
      31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
      31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535, 31'd32767,
      31'd16383, 31'd8191, 31'd4095, 31'd2047, 31'd1023, 31'd511, 31'd255,
      31'd127
   };

   // Term code: +(m+1) adds triple product m, -(m+1) subtracts it.
   // Product index bit0 = sin of first angle, bit1 second, bit2 third.
   localparam logic signed [4:0] ORDER_TERMS [NUM_ORDERS][4][2] = '{
      '{'{5'sd5, 5'sd2}, '{5'sd3, 5'sd8}, '{5'sd7, -5'sd4}, '{5'sd1, -5'sd6}},
      '{'{-5'sd7, 5'sd2}, '{5'sd3, 5'sd6}, '{5'sd5, -5'sd4}, '{5'sd1, 5'sd8}},
      '{'{5'sd5, 5'sd2}, '{-5'sd7, 5'sd4}, '{5'sd3, 5'sd8}, '{5'sd1, -5'sd6}},
      '{'{5'sd7, 5'sd2}, '{5'sd5, 5'sd4}, '{5'sd3, -5'sd6}, '{5'sd1, -5'sd8}},
      '{'{5'sd3, 5'sd8}, '{5'sd5, 5'sd2}, '{-5'sd7, 5'sd4}, '{5'sd1, -5'sd6}},
      '{'{5'sd3, -5'sd6}, '{5'sd7, 5'sd2}, '{5'sd5, 5'sd4}, '{5'sd1, -5'sd8}},
      '{'{5'sd5, -5'sd4}, '{-5'sd7, 5'sd2}, '{5'sd3, 5'sd6}, '{5'sd1, 5'sd8}},
      '{'{5'sd7, -5'sd4}, '{5'sd5, 5'sd2}, '{5'sd3, 5'sd8}, '{5'sd1, -5'sd6}},
      '{'{5'sd3, 5'sd6}, '{5'sd5, -5'sd4}, '{-5'sd7, 5'sd2}, '{5'sd1, 5'sd8}},
      '{'{5'sd3, 5'sd8}, '{5'sd7, -5'sd4}, '{5'sd5, 5'sd2}, '{5'sd1, -5'sd6}},
      '{'{5'sd5, 5'sd4}, '{5'sd3, -5'sd6}, '{5'sd7, 5'sd2}, '{5'sd1, -5'sd8}},
      '{'{-5'sd7, 5'sd4}, '{5'sd3, 5'sd8}, '{5'sd5, 5'sd2}, '{5'sd1, -5'sd6}}
   };

   typedef logic signed [17:0] angle_type;
   typedef logic signed [32:0] cordic_type;
   typedef logic signed [16:0] trig_type;
   typedef logic signed [31:0] pair_type;
   typedef logic signed [46:0] triple_type;
   typedef logic signed [47:0] sum_type;
   typedef logic signed [15:0] quat_type;

endpackage

// File: rtl/core/euler_to_quaternion.sv
// Euler / Tait-Bryan angles to unit quaternion, twelve axis orders.
// Depends on e2q_pkg for constants, the atan table and the order table.
//
// One item is accepted per clock while the result side does not stall, and
// it passes through CORDIC_STAGES + 7 register stages (16 CORDIC iterations
// by default): one stage captures
// the angles, one reduces each half angle to a quadrant, one CORDIC
// iteration per stage for all three angles, then quadrant fix and rounding,
// two multiplier stages, the signed sums and the final round and saturate.
// Each stage holds its item until the next one is free, so bubbles close up
// and a stalled result register still lets earlier stages fill. The axis
// order register (reset XYZ, codes above ZYZ act as XYZ) is read live by the
// sum stage, so it should be changed only with the pipeline empty.
module euler_to_quaternion
   import e2q_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [17:0]  req_angle_first,
   input  logic signed [17:0]  req_angle_second,
   input  logic signed [17:0]  req_angle_third,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [15:0]  rsp_quat_x,
   output logic signed [15:0]  rsp_quat_y,
   output logic signed [15:0]  rsp_quat_z,
   output logic signed [15:0]  rsp_quat_w,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [1:0]          paddr,
   input  logic [31:0]         pwdata,
   output logic [31:0]         prdata,
   output logic                pready
);

   localparam int ST_RED   = 1;
   localparam int ST_QUAD  = CORDIC_STAGES + 2;
   localparam int ST_PAIR  = CORDIC_STAGES + 3;
   localparam int ST_TRIP  = CORDIC_STAGES + 4;
   localparam int ST_SUM   = CORDIC_STAGES + 5;
   localparam int ST_OUT   = CORDIC_STAGES + 6;

   logic [3:0]              axis_order_ff;
   logic [NUM_STAGES-1:0]   valid_ff;
   logic [NUM_STAGES-1:0]   adv;

   angle_type               ang_ff [3];
   cordic_type              x_ff [CORDIC_STAGES+1][3];
   cordic_type              y_ff [CORDIC_STAGES+1][3];
   cordic_type              z_ff [CORDIC_STAGES+1][3];
   logic [1:0]              k_ff [CORDIC_STAGES+1][3];
   cordic_type              z_in [3];
   logic [1:0]              k_in [3];
   trig_type                cs_ff [3][2];
   trig_type                cs_in [3][2];
   pair_type                pp_ff [4];
   pair_type                pp_in [4];
   trig_type                third_ff [2];
   triple_type              tp_ff [8];
   triple_type              tp_in [8];
   sum_type                 sum_ff [4];
   sum_type                 sum_in [4];
   quat_type                q_ff [4];
   quat_type                q_in [4];
   logic [3:0]              order_sel;

   // ---------------- configuration ----------------
   assign pready = 1'b1;
   assign prdata = {28'd0, axis_order_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         axis_order_ff <= AXIS_ORDER_XYZ;
      end else if (psel && penable && pwrite && (paddr == 2'd0)) begin
         axis_order_ff <= pwdata[3:0];
      end
   end

   // ---------------- stage advance ----------------
   // A stage takes a new item when it is empty or its item moves on.
   always_comb begin
      adv[NUM_STAGES-1] = !valid_ff[NUM_STAGES-1] || rsp_ready;
      for (int s = NUM_STAGES - 2; s >= 0; s--) begin
         adv[s] = !valid_ff[s] || adv[s+1];
      end
   end

   assign req_ready = adv[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) begin
            valid_ff[0] <= req_valid;
         end
         for (int s = 1; s < NUM_STAGES; s++) begin
            if (adv[s]) begin
               valid_ff[s] <= valid_ff[s-1];
            end
         end
      end
   end

   // ---------------- input capture ----------------
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         ang_ff[0] <= req_angle_first;
         ang_ff[1] <= req_angle_second;
         ang_ff[2] <= req_angle_third;
      end
   end

   // ---------------- quadrant reduction ----------------
   // Half angle in Q.30 is the input shifted by 15; at most three quarter
   // turns either way fit, so the quadrant is found by fixed compares.
   always_comb begin
      logic signed [33:0] r;
      logic signed [33:0] res;
      for (int a = 0; a < 3; a++) begin
         r   = {ang_ff[a][17], ang_ff[a], 15'd0};
         res = r;
         k_in[a] = 2'd0;
         if (r > QUAD_LIMIT_3) begin
            res = r - PI_HALF_X3;  k_in[a] = 2'd3;
         end else if (r > QUAD_LIMIT_2) begin
            res = r - PI_HALF_X2;  k_in[a] = 2'd2;
         end else if (r > QUAD_LIMIT_1) begin
            res = r - PI_HALF;     k_in[a] = 2'd1;
         end else if (r < -QUAD_LIMIT_3) begin
            res = r + PI_HALF_X3;  k_in[a] = 2'd1;
         end else if (r < -QUAD_LIMIT_2) begin
            res = r + PI_HALF_X2;  k_in[a] = 2'd2;
         end else if (r < -QUAD_LIMIT_1) begin
            res = r + PI_HALF;     k_in[a] = 2'd3;
         end
         z_in[a] = res[32:0];
      end
   end

   // ---------------- CORDIC, one iteration per stage ----------------
   always_ff @(posedge clock) begin
      if (adv[ST_RED]) begin
         for (int a = 0; a < 3; a++) begin
            x_ff[0][a] <= CORDIC_GAIN;
            y_ff[0][a] <= '0;
            z_ff[0][a] <= z_in[a];
            k_ff[0][a] <= k_in[a];
         end
      end
      for (int j = 1; j <= CORDIC_STAGES; j++) begin
         if (adv[ST_RED + j]) begin
            for (int a = 0; a < 3; a++) begin
               k_ff[j][a] <= k_ff[j-1][a];
               if (z_ff[j-1][a] >= 0) begin
                  x_ff[j][a] <= x_ff[j-1][a] - (y_ff[j-1][a] >>> (j - 1));
                  y_ff[j][a] <= y_ff[j-1][a] + (x_ff[j-1][a] >>> (j - 1));
                  z_ff[j][a] <= z_ff[j-1][a] - $signed({2'b00, ATAN_Q30[j-1]});
               end else begin
                  x_ff[j][a] <= x_ff[j-1][a] + (y_ff[j-1][a] >>> (j - 1));
                  y_ff[j][a] <= y_ff[j-1][a] - (x_ff[j-1][a] >>> (j - 1));
                  z_ff[j][a] <= z_ff[j-1][a] + $signed({2'b00, ATAN_Q30[j-1]});
               end
            end
         end
      end
   end

   // ---------------- quadrant fix and rounding to Q.15 ----------------
   always_comb begin
      logic signed [33:0] c;
      logic signed [33:0] s;
      logic signed [33:0] cr;
      logic signed [33:0] sr;
      for (int a = 0; a < 3; a++) begin
         c = 34'(x_ff[CORDIC_STAGES][a]);
         s = 34'(y_ff[CORDIC_STAGES][a]);
         case (k_ff[CORDIC_STAGES][a])
            2'd1:    begin cr = -s; sr = c;  end
            2'd2:    begin cr = -c; sr = -s; end
            2'd3:    begin cr = s;  sr = -c; end
            default: begin cr = c;  sr = s;  end
         endcase
         cr = cr + 34'sd16384;
         sr = sr + 34'sd16384;
         cs_in[a][0] = cr[31:15];
         cs_in[a][1] = sr[31:15];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_QUAD]) begin
         cs_ff <= cs_in;
      end
   end

   // ---------------- products ----------------
   always_comb begin
      logic signed [33:0] full;
      for (int m = 0; m < 4; m++) begin
         full     = cs_ff[0][m[0]] * cs_ff[1][m[1]];
         pp_in[m] = full[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_PAIR]) begin
         pp_ff       <= pp_in;
         third_ff[0] <= cs_ff[2][0];
         third_ff[1] <= cs_ff[2][1];
      end
   end

   always_comb begin
      logic signed [48:0] full;
      for (int m = 0; m < 8; m++) begin
         full     = pp_ff[m[1:0]] * third_ff[m[2]];
         tp_in[m] = full[46:0];
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_TRIP]) begin
         tp_ff <= tp_in;
      end
   end

   // ---------------- signed sums by axis order ----------------
   assign order_sel = (axis_order_ff > AXIS_ORDER_MAX) ? AXIS_ORDER_XYZ : axis_order_ff;

   always_comb begin
      logic signed [4:0] code;
      logic signed [4:0] mag;
      logic [2:0]        idx;
      sum_type           term;
      for (int q = 0; q < 4; q++) begin
         sum_in[q] = '0;
         for (int t = 0; t < 2; t++) begin
            code = ORDER_TERMS[order_sel][q][t];
            mag  = code[4] ? -code : code;
            mag  = mag - 5'sd1;
            idx  = mag[2:0];
            term = 48'(tp_ff[idx]);
            sum_in[q] = code[4] ? sum_in[q] - term : sum_in[q] + term;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_SUM]) begin
         sum_ff <= sum_in;
      end
   end

   // ---------------- round and saturate ----------------
   always_comb begin
      logic signed [47:0] t;
      logic signed [17:0] v;
      for (int q = 0; q < 4; q++) begin
         t = sum_ff[q] + 48'sd536870912;
         v = t[47:30];
         if (v > 18'sd32767) begin
            q_in[q] = 16'sh7fff;
         end else if (v < -18'sd32768) begin
            q_in[q] = -16'sh8000;
         end else begin
            q_in[q] = v[15:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv[ST_OUT]) begin
         q_ff <= q_in;
      end
   end

   assign rsp_valid  = valid_ff[ST_OUT];
   assign rsp_quat_x = q_ff[0];
   assign rsp_quat_y = q_ff[1];
   assign rsp_quat_z = q_ff[2];
   assign rsp_quat_w = q_ff[3];

endmodule

// File: rtl/core/e2q_port_check.sv
// Port-level checker for euler_to_quaternion, bound to the top level.
// Depends on e2q_pkg for the register reset value.
module e2q_port_check
   import e2q_pkg::*;
(
   input logic                clock,
   input logic                reset,
   input logic                rsp_valid,
   input logic                rsp_ready,
   input logic signed [15:0]  rsp_quat_x,
   input logic signed [15:0]  rsp_quat_w,
   input logic                psel,
   input logic                penable,
   input logic                pwrite,
   input logic [31:0]         pwdata,
   input logic [31:0]         prdata,
   input logic                pready
);

   // nothing leaves the block in the cycle after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_reset_order: assert property (@(posedge clock)
      reset |=> prdata == {28'd0, AXIS_ORDER_XYZ})
      else $error("axis order not XYZ after reset");

   // a register write is seen on the read data next cycle
   a_write_back: assert property (@(posedge clock) disable iff (reset)
      psel && penable && pwrite && pready |=> prdata == {28'd0, $past(pwdata[3:0])})
      else $error("axis order write not reflected");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_quat_x) && $stable(rsp_quat_w))
      else $error("stalled result transfer changed");

endmodule

bind euler_to_quaternion e2q_port_check u_e2q_port_check (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_valid),
   .rsp_ready  (rsp_ready),
   .rsp_quat_x (rsp_quat_x),
   .rsp_quat_w (rsp_quat_w),
   .psel       (psel),
   .penable    (penable),
   .pwrite     (pwrite),
   .pwdata     (pwdata),
   .prdata     (prdata),
   .pready     (pready)
);

// File: bench/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for euler_to_quaternion: random and directed angles,
// all axis orders via the APB-style port. Depends on e2q_pkg and the RTL.

class quat_scoreboard;
   typedef struct {
      logic signed [15:0] x, y, z, w;
   } quat_rec_type;

   quat_rec_type pending[$];
   int errors = 0;
   logic [3:0] order = e2q_pkg::AXIS_ORDER_XYZ;

   static function longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   static function void half_trig(logic signed [17:0] ang, output longint c15,
                                  output longint s15);
      longint r, x, y, c, s, t, dx, dy;
      int k;
      r = longint'(ang) * 32768;
      x = 652032874; y = 0; k = 0;
      while (r > 843314857) begin r -= 1686629713; k++; end
      while (r < -843314857) begin r += 1686629713; k--; end
      for (int i = 0; i < e2q_pkg::CORDIC_STAGES && i < 24; i++) begin
         dx = floor_shr(y, i); dy = floor_shr(x, i);
         if (r >= 0) begin
            x -= dx; y += dy; r -= longint'(e2q_pkg::ATAN_Q30[i]);
         end else begin
            x += dx; y -= dy; r += longint'(e2q_pkg::ATAN_Q30[i]);
         end
      end
      c = x; s = y;
      case (k & 3)
         1: begin t = c; c = -s; s = t; end
         2: begin c = -c; s = -s; end
         3: begin t = c; c = s; s = -t; end
         default: ;
      endcase
      c15 = floor_shr(c + 16384, 15);
      s15 = floor_shr(s + 16384, 15);
   endfunction

   function void note_angles(logic signed [17:0] a0, a1, a2);
      longint cs[3][2];
      longint prod[8];
      longint sum, v;
      longint comp[4];
      int sel, code;
      quat_rec_type q;
      half_trig(a0, cs[0][0], cs[0][1]);
      half_trig(a1, cs[1][0], cs[1][1]);
      half_trig(a2, cs[2][0], cs[2][1]);
      for (int m = 0; m < 8; m++)
         prod[m] = cs[0][m & 1] * cs[1][(m >> 1) & 1] * cs[2][(m >> 2) & 1];
      sel = int'((order <= e2q_pkg::AXIS_ORDER_MAX) ? order : e2q_pkg::AXIS_ORDER_XYZ);
      for (int c = 0; c < 4; c++) begin
         sum = 0;
         for (int t = 0; t < 2; t++) begin
            code = e2q_pkg::ORDER_TERMS[sel][c][t];
            if (code > 0) sum += prod[code - 1];
            else sum -= prod[-code - 1];
         end
         v = floor_shr(sum + (longint'(1) << 29), 30);
         if (v > 32767) v = 32767;
         if (v < -32768) v = -32768;
         comp[c] = v;
      end
      q.x = 16'(comp[0]); q.y = 16'(comp[1]); q.z = 16'(comp[2]); q.w = 16'(comp[3]);
      pending.push_back(q);
   endfunction

   function void check_quat(logic signed [15:0] x, y, z, w);
      quat_rec_type e;
      if (pending.size() == 0) begin
         $display("%0t: unexpected transfer %0d %0d %0d %0d", $time, x, y, z, w);
         errors++;
         return;
      end
      e = pending.pop_front();
      if (e.x !== x || e.y !== y || e.z !== z || e.w !== w) begin
         $display("%0t: expected %0d %0d %0d %0d actual %0d %0d %0d %0d", $time,
                  e.x, e.y, e.z, e.w, x, y, z, w);
         errors++;
      end
   endfunction
endclass

module tb;
   import e2q_pkg::*;

   localparam int LATENCY = NUM_STAGES;

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready;
   logic signed [17:0] req_angle_first, req_angle_second, req_angle_third;
   logic signed [15:0] rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w;
   logic psel, penable, pwrite, pready;
   logic [1:0] paddr;
   logic [31:0] pwdata, prdata;
   bit quiet;

   quat_scoreboard quat_sb;

   euler_to_quaternion u_dut (.*);

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("euler_to_quaternion: mismatch");
      $finish;
   end

   // result side: random stall, checks every transfer
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready)
            quat_sb.check_quat(rsp_quat_x, rsp_quat_y, rsp_quat_z, rsp_quat_w);
         rsp_ready <= quiet || ($urandom_range(99) >= 14);
      end
   end

   task automatic write_order(logic [3:0] value);
      psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= 32'(value);
      @(posedge clock);
      penable <= 1;
      @(posedge clock);
      psel <= 0; penable <= 0; pwrite <= 0;
      quat_sb.order = value;
   endtask

   task automatic send_angles(logic signed [17:0] a0, a1, a2);
      while (!quiet && $urandom_range(99) < 14) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_angle_first <= a0; req_angle_second <= a1; req_angle_third <= a2;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      quat_sb.note_angles(a0, a1, a2);
   endtask

   task automatic drain();
      req_valid <= 0;
      @(posedge clock);
      while (quat_sb.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   function automatic logic signed [17:0] rand_angle();
      case ($urandom_range(3))
         0: return $urandom_range(5) == 0 ? -18'sd131072 : 18'sd131071;
         1: return 18'($urandom_range(51472)) - 18'sd25736; // about +-pi/2
         default: return 18'($urandom);
      endcase
   endfunction

   initial begin
      logic signed [17:0] edge_vals[8];
      quat_sb = new();
      reset = 1; req_valid = 0; rsp_ready = 0; psel = 0; penable = 0; pwrite = 0;
      paddr = 0; pwdata = 0; req_angle_first = 0; req_angle_second = 0;
      req_angle_third = 0; quiet = 0;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset order, then quadrant boundaries and range ends
      edge_vals = '{18'sd0, 18'sd131071, -18'sd131072, 18'sd25736, -18'sd25736,
                    18'sd12868, -18'sd12868, 18'sd51472};
      for (int i = 0; i < 8; i++)
         send_angles(edge_vals[i], edge_vals[(i + 3) % 8], edge_vals[(i + 5) % 8]);
      drain();
      // every order once, plus codes above ZYZ
      for (int o = 0; o < 16; o++) begin
         write_order(4'(o));
         send_angles(18'sd3000, -18'sd7000, 18'sd20000);
         drain();
      end

      for (int n = 0; n < 1750; n++) begin
         if (n % 125 == 0) begin
            drain();
            write_order(n == 0 ? 4'd0 : (n == 125 ? 4'd11 : 4'($urandom_range(15))));
         end
         quiet = (n >= 700 && n < 900);
         send_angles(rand_angle(), rand_angle(), rand_angle());
      end
      quiet = 0;
      drain();

      if (quat_sb.errors == 0 && quat_sb.pending.size() == 0)
         $display("euler_to_quaternion: match");
      else
         $display("euler_to_quaternion: mismatch");
      $finish;
   end
endmodule
